// File: hw/rtl/u8sd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder
// Command word passed from the byte classifier to the result sequencer.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int REP_W  = 3;   // up to four replacement results per byte

  localparam logic [CP_W-1:0] REPL_CHAR = 21'h00FFFD;

  // One command per byte that yields results: rep replacement characters,
  // then optionally one decoded value.
  typedef struct packed {
    logic [REP_W-1:0] rep;
    logic             has_value;
    logic [CP_W-1:0]  value;
    logic             last;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// File: hw/rtl/u8sd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_front: byte classifier
// Tracks the pending sequence and turns each byte that yields results into one command word.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [u8sd_pkg::BYTE_W-1:0]   in_byte,
  input  logic                          last_byte,
  input  logic                          q_full,
  output logic                          push,
  output u8sd_pkg::cmd_t                push_cmd
);
  import u8sd_pkg::*;

  logic [1:0]       bytes_expected, bytes_expected_next;
  logic [1:0]       bytes_held, bytes_held_next;
  logic [CP_W-1:0]  partial_value, partial_value_next;
  logic [REP_W-1:0] rep;
  logic             has_value;
  logic [CP_W-1:0]  value;
  logic             accept;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    bytes_expected_next = bytes_expected;
    bytes_held_next     = bytes_held;
    partial_value_next  = partial_value;
    rep                 = '0;
    has_value           = 1'b0;
    value               = '0;
    if (bytes_expected != 2'd0 && in_byte[7:6] == 2'b10) begin
      partial_value_next  = {partial_value[CP_W-7:0], in_byte[5:0]};
      bytes_expected_next = bytes_expected - 2'd1;
      bytes_held_next     = bytes_held + 2'd1;
      if (bytes_expected_next == 2'd0) begin
        has_value          = 1'b1;
        value              = partial_value_next;
        bytes_held_next    = 2'd0;
        partial_value_next = '0;
      end
    end else begin
      // drop any pending sequence, then treat the byte as a lead
      rep                 = (bytes_expected != 2'd0) ? {1'b0, bytes_held} : '0;
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      partial_value_next  = '0;
      unique casez (in_byte)
        8'b0???????: begin
          has_value = 1'b1;
          value     = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        end
        8'b110?????: begin
          partial_value_next  = {{(CP_W-5){1'b0}}, in_byte[4:0]};
          bytes_expected_next = 2'd1;
          bytes_held_next     = 2'd1;
        end
        8'b1110????: begin
          partial_value_next  = {{(CP_W-4){1'b0}}, in_byte[3:0]};
          bytes_expected_next = 2'd2;
          bytes_held_next     = 2'd1;
        end
        8'b11110???: begin
          partial_value_next  = {{(CP_W-3){1'b0}}, in_byte[2:0]};
          bytes_expected_next = 2'd3;
          bytes_held_next     = 2'd1;
        end
        default: rep = rep + 3'd1;
      endcase
    end
    // end of string: cut sequence turns into replacements
    if (last_byte) begin
      if (bytes_expected_next != 2'd0) rep = rep + {1'b0, bytes_held_next};
      bytes_expected_next = 2'd0;
      bytes_held_next     = 2'd0;
      partial_value_next  = '0;
    end
  end

  assign push               = accept && (rep != '0 || has_value);
  assign push_cmd.rep       = rep;
  assign push_cmd.has_value = has_value;
  assign push_cmd.value     = value;
  assign push_cmd.last      = last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected <= 2'd0;
      bytes_held     <= 2'd0;
      partial_value  <= '0;
    end else if (accept) begin
      bytes_expected <= bytes_expected_next;
      bytes_held     <= bytes_held_next;
      partial_value  <= partial_value_next;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    bytes_expected == 2'd0 |-> bytes_held == 2'd0 && partial_value == '0)
    else $error("idle decoder holds stale sequence state");

  a_seq_len: assert property (@(posedge clk) disable iff (rst)
    bytes_expected != 2'd0 |->
      bytes_held != 2'd0 && ({1'b0, bytes_held} + {1'b0, bytes_expected}) <= 3'd4)
    else $error("pending sequence length out of range");

endmodule

// File: hw/rtl/u8sd_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_cmd_fifo: command queue
// Small flop-based queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module u8sd_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8sd_pkg::cmd_t    push_cmd,
  output logic              full,
  input  logic              pop,
  output u8sd_pkg::head_t   head
);
  import u8sd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers wrap at the last entry, so any depth works
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("command queue overflow");

endmodule

// File: hw/rtl/u8sd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8sd_back: result sequencer
// Expands each command into its results, one transfer per cycle while result_ready is high.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  u8sd_pkg::head_t             head,
  output logic                        pop,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [u8sd_pkg::CP_W-1:0]   code_point,
  output logic                        is_replacement,
  output logic                        run_last,
  output logic                        string_done
);
  import u8sd_pkg::*;

  logic  act_valid;
  cmd_t  act;
  cmd_t  src;
  logic  src_valid;
  logic  issue;
  logic  res_final;
  cmd_t  act_next;

  // a command in progress takes precedence over the queue head
  assign src       = act_valid ? act : head.cmd;
  assign src_valid = act_valid || head.valid;
  assign issue     = src_valid && (!result_valid || result_ready);
  assign res_final = (src.rep == '0) || (src.rep == REP_W'(1) && !src.has_value);
  assign pop       = issue && !act_valid;

  always_comb begin
    act_next     = src;
    act_next.rep = src.rep - REP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (issue) act_valid <= !res_final;
      if (issue) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      act            <= act_next;
      code_point     <= (src.rep != '0) ? REPL_CHAR : src.value;
      is_replacement <= (src.rep != '0);
      run_last       <= res_final;
      string_done    <= res_final && src.last;
    end
  end

  a_act_nonempty: assert property (@(posedge clk) disable iff (rst)
    act_valid |-> act.rep != '0 || act.has_value)
    else $error("sequencer holds an empty command");

  a_split_cmd: assert property (@(posedge clk) disable iff (rst)
    issue && !act_valid && !res_final |=> act_valid)
    else $error("multi-result command lost after first result");

endmodule

// File: hw/rtl/utf8_stream_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit: UTF-8 byte stream to code point decoder
// Classifier front end, command queue, and result sequencer back end.
// ----------------------------------------------------------------------------
//  channel | handshake                   | payload
//  --------+-----------------------------+-------------------------------------
//  bytes   | byte_valid / byte_ready     | in_byte, last_byte
//  results | result_valid / result_ready | code_point, is_replacement,
//          |                             | run_last, string_done
//
//  One byte accepted per cycle while the queue has room; a byte that yields
//  k results (at most four) holds the sequencer until all k have issued.
//  Results leave from an output register, one transfer per cycle while result_ready is high.
//  A stalled result side fills the FIFO_DEPTH-entry queue, then byte_ready drops.
//  Synchronous reset clears the sequence state, the queue and result_valid.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [u8sd_pkg::BYTE_W-1:0] in_byte,
  input  logic                        last_byte,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [u8sd_pkg::CP_W-1:0]   code_point,
  output logic                        is_replacement,
  output logic                        run_last,
  output logic                        string_done
);
  import u8sd_pkg::*;

  logic  q_full;
  logic  push;
  cmd_t  push_cmd;
  logic  pop;
  head_t head;

  u8sd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  u8sd_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  u8sd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .run_last       (run_last),
    .string_done    (string_done)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: UTF-8 stream decoder testbench
// Drives bytes with end-of-string flags through the byte channel and checks
// each code point transfer against an in-bench decoder model. A short table
// of directed bytes comes first, then random well-formed, cut and noise
// sequences, with bursty sending and patterned result stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import u8sd_pkg::*;

  localparam int ROW_PRED = 0;   // expectation from the decoder model
  localparam int ROW_NONE = 1;   // byte gives no code point
  localparam int ROW_ONE  = 2;   // one typed-in code point
  localparam int N_ROWS   = 26;
  localparam int N_RAND   = 154;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            repl;
    logic            run_end;
    logic            str_end;
  } code_result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [1:0]        kind;
    logic [CP_W-1:0]   cp;
    logic              repl;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_ready;
  logic [BYTE_W-1:0] in_byte = '0;
  logic              last_byte = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [CP_W-1:0]   code_point;
  logic              is_replacement;
  logic              run_last;
  logic              string_done;

  // decoder model state
  logic [1:0]        need_cnt = '0;
  logic [1:0]        held_cnt = '0;
  logic [CP_W-1:0]   acc_value = '0;

  code_result_t      exp_cps[$];
  code_result_t      step_cps[$];
  code_result_t      got_cp;
  code_result_t      want_cp;
  stim_row_t         dir_rows[N_ROWS];
  int                mismatches = 0;
  int                burst_left = 0;
  int                sent_cnt = 0;
  logic [7:0]        stall_phase = '0;

  utf8_stream_decoder_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_ready     (byte_ready),
    .in_byte        (in_byte),
    .last_byte      (last_byte),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .code_point     (code_point),
    .is_replacement (is_replacement),
    .run_last       (run_last),
    .string_done    (string_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- model
  task automatic stage_cp(input logic [CP_W-1:0] cp, input logic repl);
    code_result_t r;
    r.cp      = cp;
    r.repl    = repl;
    r.run_end = 1'b0;
    r.str_end = 1'b0;
    step_cps.push_back(r);
  endtask

  task automatic flush_pending();
    int k;
    for (k = 0; k < held_cnt; k++) stage_cp(REPL_CHAR, 1'b1);
    need_cnt  = '0;
    held_cnt  = '0;
    acc_value = '0;
  endtask

  task automatic start_seq(input logic [BYTE_W-1:0] b);
    if (b[7] == 1'b0) begin
      stage_cp({13'd0, b}, 1'b0);
    end else if (b[7:5] == 3'b110) begin
      acc_value = {16'd0, b[4:0]};
      need_cnt  = 2'd1;
      held_cnt  = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      acc_value = {17'd0, b[3:0]};
      need_cnt  = 2'd2;
      held_cnt  = 2'd1;
    end else if (b[7:3] == 5'b11110) begin
      acc_value = {18'd0, b[2:0]};
      need_cnt  = 2'd3;
      held_cnt  = 2'd1;
    end else begin
      stage_cp(REPL_CHAR, 1'b1);
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last, input bit keep);
    code_result_t r;
    int n;
    step_cps.delete();
    if (need_cnt != 0) begin
      if (b[7:6] == 2'b10) begin
        acc_value = {acc_value[CP_W-7:0], b[5:0]};
        held_cnt  = held_cnt + 2'd1;
        need_cnt  = need_cnt - 2'd1;
        if (need_cnt == 0) begin
          stage_cp(acc_value, 1'b0);
          held_cnt  = '0;
          acc_value = '0;
        end
      end else begin
        // broken sequence: replace held bytes, then reread this one as a lead
        flush_pending();
        start_seq(b);
      end
    end else begin
      start_seq(b);
    end
    if (last && need_cnt != 0) flush_pending();
    if (last) begin
      need_cnt  = '0;
      held_cnt  = '0;
      acc_value = '0;
    end
    n = step_cps.size();
    if (n > 0) begin
      r = step_cps[n-1];
      r.run_end = 1'b1;
      r.str_end = last;
      step_cps[n-1] = r;
    end
    if (keep) begin
      foreach (step_cps[i]) exp_cps.push_back(step_cps[i]);
    end
  endtask

  // ---------------------------------------------------------------- driver
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last, input bit keep);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    byte_valid <= 1'b1;
    in_byte    <= b;
    last_byte  <= last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_byte(b, last, keep);
    sent_cnt++;
  endtask

  // hold the byte side off until every pending code point has come out
  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (exp_cps.size() > 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic rand_last();
    return ($urandom_range(0, 9) == 0);
  endfunction

  task automatic send_char(input int len, input bit cut);
    logic [31:0] bits;
    logic [BYTE_W-1:0] seq[4];
    int n_send;
    int k;
    bits = $urandom;
    case (len)
      1: seq[0] = {1'b0, bits[6:0]};
      2: seq[0] = {3'b110, bits[4:0]};
      3: seq[0] = {4'b1110, bits[3:0]};
      default: seq[0] = {5'b11110, bits[2:0]};
    endcase
    for (k = 1; k < 4; k++) seq[k] = {2'b10, bits[6*k+7 -: 6]};
    n_send = (cut && len > 1) ? $urandom_range(1, len - 1) : len;
    for (k = 0; k < n_send; k++) send_byte(seq[k], rand_last(), 1'b1);
  endtask

  function automatic stim_row_t mk_row(input logic [BYTE_W-1:0] d, input logic last,
                                       input int kind, input logic [CP_W-1:0] cp,
                                       input logic repl);
    stim_row_t r;
    r.data = d;
    r.last = last;
    r.kind = kind[1:0];
    r.cp   = cp;
    r.repl = repl;
    return r;
  endfunction

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0: result_ready <= 1'b1;
      2'd1: result_ready <= 1'($urandom_range(0, 1));
      2'd2: result_ready <= (stall_phase[1:0] == 2'd0);
      default: result_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_cp = {code_point, is_replacement, run_last, string_done};
      if (exp_cps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: cp=%h repl=%b run_last=%b done=%b",
                   got_cp.cp, got_cp.repl, got_cp.run_end, got_cp.str_end);
      end else begin
        want_cp = exp_cps.pop_front();
        if (got_cp.cp !== want_cp.cp || got_cp.repl !== want_cp.repl ||
            got_cp.run_end !== want_cp.run_end || got_cp.str_end !== want_cp.str_end) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp cp=%h repl=%b run_last=%b done=%b",
                     want_cp.cp, want_cp.repl, want_cp.run_end, want_cp.str_end);
            $display("          got cp=%h repl=%b run_last=%b done=%b",
                     got_cp.cp, got_cp.repl, got_cp.run_end, got_cp.str_end);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    code_result_t typed;
    int kind;
    int wait_cnt;

    dir_rows[0]  = mk_row(8'h00, 1'b0, ROW_ONE,  21'h000000, 1'b0);
    dir_rows[1]  = mk_row(8'h7F, 1'b1, ROW_ONE,  21'h00007F, 1'b0);
    dir_rows[2]  = mk_row(8'h80, 1'b0, ROW_ONE,  REPL_CHAR,  1'b1);  // stray continuation
    dir_rows[3]  = mk_row(8'hFF, 1'b0, ROW_ONE,  REPL_CHAR,  1'b1);  // invalid lead
    dir_rows[4]  = mk_row(8'hF8, 1'b1, ROW_ONE,  REPL_CHAR,  1'b1);
    dir_rows[5]  = mk_row(8'hC2, 1'b0, ROW_NONE, '0, 1'b0);
    dir_rows[6]  = mk_row(8'hA9, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[7]  = mk_row(8'hE2, 1'b0, ROW_NONE, '0, 1'b0);
    dir_rows[8]  = mk_row(8'h82, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[9]  = mk_row(8'hAC, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[10] = mk_row(8'hF0, 1'b0, ROW_NONE, '0, 1'b0);
    dir_rows[11] = mk_row(8'h9F, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[12] = mk_row(8'h98, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[13] = mk_row(8'h80, 1'b0, ROW_PRED, '0, 1'b0);
    // largest four-byte value, ending the string
    dir_rows[14] = mk_row(8'hF7, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[15] = mk_row(8'hBF, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[16] = mk_row(8'hBF, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[17] = mk_row(8'hBF, 1'b1, ROW_PRED, '0, 1'b0);
    // bad continuation, offending byte decoded as ASCII
    dir_rows[18] = mk_row(8'hE0, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[19] = mk_row(8'h80, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[20] = mk_row(8'h41, 1'b0, ROW_PRED, '0, 1'b0);
    // bad continuation that starts a lead on the final byte: four replacements
    dir_rows[21] = mk_row(8'hF0, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[22] = mk_row(8'h90, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[23] = mk_row(8'h80, 1'b0, ROW_PRED, '0, 1'b0);
    dir_rows[24] = mk_row(8'hC3, 1'b1, ROW_PRED, '0, 1'b0);
    // string ends right on a lead byte
    dir_rows[25] = mk_row(8'hC0, 1'b1, ROW_PRED, '0, 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].kind == ROW_PRED);
      if (dir_rows[i].kind == ROW_ONE) begin
        typed.cp      = dir_rows[i].cp;
        typed.repl    = dir_rows[i].repl;
        typed.run_end = 1'b1;
        typed.str_end = dir_rows[i].last;
        exp_cps.push_back(typed);
      end
    end
    drain_results();

    sent_cnt = 0;
    while (sent_cnt < N_RAND) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) send_char($urandom_range(1, 4), 1'b0);
      else if (kind == 7) send_char($urandom_range(2, 4), 1'b1);
      else send_byte(BYTE_W'($urandom_range(0, 255)), rand_last(), 1'b1);
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    byte_valid <= 1'b0;
    wait_cnt = 0;
    while (exp_cps.size() > 0 && wait_cnt < 5000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (exp_cps.size() > 0) begin
      mismatches += exp_cps.size();
      $display("%0d code points never arrived", exp_cps.size());
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
